/* hw/rtl/playfair_digraph_decrypt_unit_assert.svh */
// Assertion macros for the Playfair digraph decrypt unit.
`ifndef PLAYFAIR_DIGRAPH_DECRYPT_UNIT_ASSERT_SVH
`define PLAYFAIR_DIGRAPH_DECRYPT_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled in reset
`define PFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pfd assertion failed");
// next-cycle implication, disabled in reset
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pfd assertion failed");
`else
`define PFD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PFD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/pfd_pkg.sv */
// Package for the Playfair digraph decrypt unit: sizes, types, lookup functions.
package pfd_pkg;

  localparam int SIDE   = 5;
  localparam int NCELL  = SIDE * SIDE;
  localparam int CODE_W = 5;
  localparam int ROW_W  = SIDE * CODE_W;
  localparam int RC_W   = $clog2(SIDE);
  localparam int IDX_W  = 3;

  localparam logic [RC_W-1:0] LAST_RC = RC_W'(SIDE - 1);

  localparam logic [IDX_W-1:0] CFG_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] CFG_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] CFG_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] CFG_ROW3 = 3'd3;
  localparam logic [IDX_W-1:0] CFG_ROW4 = 3'd4;

  typedef logic [SIDE-1:0][ROW_W-1:0] square_t;
  typedef logic [NCELL-1:0] match_t;

  typedef struct packed {
    logic            found;
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } loc_t;

  typedef struct packed {
    logic [RC_W-1:0] row;
    logic [RC_W-1:0] col;
  } pos_t;

  // bit r*SIDE+c is set where the square holds code
  function automatic match_t match_code(square_t sq, logic [CODE_W-1:0] code);
    match_t m;
    m = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        m[r*SIDE+c] = (sq[r][c*CODE_W +: CODE_W] == code);
      end
    end
    return m;
  endfunction

  // first match in row-major order
  function automatic loc_t first_loc(match_t m);
    loc_t l;
    l.found = |m;
    l.row = '0;
    l.col = '0;
    for (int i = NCELL - 1; i >= 0; i--) begin
      if (m[i]) begin
        l.row = RC_W'(i / SIDE);
        l.col = RC_W'(i % SIDE);
      end
    end
    return l;
  endfunction

  function automatic logic [RC_W-1:0] dec_wrap(logic [RC_W-1:0] v);
    return (v == '0) ? LAST_RC : v - RC_W'(1);
  endfunction

  function automatic logic [CODE_W-1:0] cell_at(square_t sq, pos_t p);
    logic [CODE_W-1:0] v;
    v = '0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (p.row == RC_W'(r) && p.col == RC_W'(c)) begin
          v = sq[r][c*CODE_W +: CODE_W];
        end
      end
    end
    return v;
  endfunction

endpackage

/* hw/rtl/playfair_digraph_decrypt_unit.sv */
// Playfair digraph decryption over a 5x5 key square, four-stage pipeline.
//
// Usage:
//   Key square: five rows written over the cfg channel (cfg_valid/cfg_ready,
//   cfg_index 0..4 selects the row, cfg_data packs five 5-bit codes with
//   column 0 lowest). Indexes above 4 are ignored. cfg_ready is always high;
//   write rows only while no item is in flight.
//   Input: one ciphertext digraph per item on in_valid/in_ready.
//   Output: one plaintext digraph plus letter_missing per item on
//   out_valid/out_ready. letter_missing forces both letters to zero.
//   Order: the accepting edge registers the match, then locate, target
//   select and cell read follow, each in its own registered stage.
//   Throughput: one item per cycle while out_ready is high; each stage
//   holds one item.
//   Stall: when out_ready is low, stages fill bubbles first, then hold;
//   in_ready drops only when all four stages are occupied.
//   Reset: rst (synchronous) empties the pipeline and clears the square to 0.
`include "playfair_digraph_decrypt_unit_assert.svh"

module playfair_digraph_decrypt_unit
  import pfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [ROW_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] cipher_first,
  input  logic [CODE_W-1:0] cipher_second,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CODE_W-1:0] plain_first,
  output logic [CODE_W-1:0] plain_second,
  output logic              letter_missing
);

  square_t square;

  logic   s1_valid, s2_valid, s3_valid;
  logic   s1_ready, s2_ready, s3_ready, s4_ready;
  match_t s1_match_a, s1_match_b;
  loc_t   s2_loc_a, s2_loc_b;
  pos_t   s3_pos_a, s3_pos_b;
  logic   s3_missing;
  pos_t   tgt_a, tgt_b;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      square <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW0: square[0] <= cfg_data;
        CFG_ROW1: square[1] <= cfg_data;
        CFG_ROW2: square[2] <= cfg_data;
        CFG_ROW3: square[3] <= cfg_data;
        CFG_ROW4: square[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage takes a new item when empty or when its item moves on
  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  // stage 1: compare against all 25 cells
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_match_a <= match_code(square, cipher_first);
      s1_match_b <= match_code(square, cipher_second);
    end
  end

  // stage 2: priority encode to row and column
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_loc_a <= first_loc(s1_match_a);
      s2_loc_b <= first_loc(s1_match_b);
    end
  end

  // stage 3: Playfair rule selects the cell to read
  always_comb begin
    if (s2_loc_a.row == s2_loc_b.row) begin
      tgt_a = '{row: s2_loc_a.row, col: dec_wrap(s2_loc_a.col)};
      tgt_b = '{row: s2_loc_b.row, col: dec_wrap(s2_loc_b.col)};
    end else if (s2_loc_a.col == s2_loc_b.col) begin
      tgt_a = '{row: dec_wrap(s2_loc_a.row), col: s2_loc_a.col};
      tgt_b = '{row: dec_wrap(s2_loc_b.row), col: s2_loc_b.col};
    end else begin
      tgt_a = '{row: s2_loc_a.row, col: s2_loc_b.col};
      tgt_b = '{row: s2_loc_b.row, col: s2_loc_a.col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_pos_a   <= tgt_a;
      s3_pos_b   <= tgt_b;
      s3_missing <= !s2_loc_a.found || !s2_loc_b.found;
    end
  end

  // stage 4: cell read into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      letter_missing <= s3_missing;
      plain_first    <= s3_missing ? '0 : cell_at(square, s3_pos_a);
      plain_second   <= s3_missing ? '0 : cell_at(square, s3_pos_b);
    end
  end

  `PFD_ASSERT_IMPL(a_missing_zero, clk, rst, out_valid && letter_missing,
                   plain_first == '0 && plain_second == '0)
  `PFD_ASSERT_NEXT(a_found_matches, clk, rst, s1_valid && s2_ready,
                   s2_valid && s2_loc_a.found == ($past(s1_match_a) != '0) &&
                   s2_loc_b.found == ($past(s1_match_b) != '0))
  `PFD_ASSERT_IMPL(a_target_range, clk, rst, s3_valid,
                   s3_pos_a.row <= LAST_RC && s3_pos_a.col <= LAST_RC &&
                   s3_pos_b.row <= LAST_RC && s3_pos_b.col <= LAST_RC)
  `PFD_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, s1_valid)

endmodule

/* tb/playfair_digraph_decrypt_unit_tb.sv */
// Testbench for the Playfair digraph decrypt unit: directed and random digraphs, scoreboard check.
`timescale 1ns / 1ps

module playfair_digraph_decrypt_unit_tb;
  import pfd_pkg::*;

  localparam int LATENCY    = 4;
  localparam int LONG_HOLD  = 60;
  localparam int RAND_ITEMS = 170;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [CODE_W-1:0] first_letter;
    logic [CODE_W-1:0] second_letter;
    logic              missing;
  } plain_pair_t;

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [ROW_W-1:0]  cfg_data;
  logic              in_valid;
  logic              in_ready;
  logic [CODE_W-1:0] cipher_first;
  logic [CODE_W-1:0] cipher_second;
  logic              out_valid;
  logic              out_ready;
  logic [CODE_W-1:0] plain_first;
  logic [CODE_W-1:0] plain_second;
  logic              letter_missing;

  // predictor copy of the key square and the digraphs still owed by the block
  square_t     key_square;
  plain_pair_t plain_expected[$];
  // square the stimulus draws letters from
  square_t     stim_square;

  int error_count;
  logic tx_idle_en;
  logic rx_idle_en;
  logic rx_hold_req;
  int rx_gap_left;
  int rx_hold_left;

  playfair_digraph_decrypt_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cipher_first  (cipher_first),
    .cipher_second (cipher_second),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .plain_first   (plain_first),
    .plain_second  (plain_second),
    .letter_missing(letter_missing)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("playfair_digraph_decrypt_unit_tb: FAIL");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [CODE_W-1:0] letter_at(input int row, input int col);
    return key_square[row][col*CODE_W +: CODE_W];
  endfunction

  // first hit in row-major order wins
  function automatic logic find_letter(input logic [CODE_W-1:0] code,
                                       output int row, output int col);
    row = 0;
    col = 0;
    for (int r = 0; r < SIDE; r++) begin
      for (int c = 0; c < SIDE; c++) begin
        if (key_square[r][c*CODE_W +: CODE_W] == code) begin
          row = r;
          col = c;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic plain_pair_t decrypt_digraph(input logic [CODE_W-1:0] a,
                                                  input logic [CODE_W-1:0] b);
    plain_pair_t res;
    int ra, ca, rb, cb;
    logic fa, fb;
    res = '0;
    fa = find_letter(a, ra, ca);
    fb = find_letter(b, rb, cb);
    if (!fa || !fb) begin
      res.missing = 1'b1;
    end else if (ra == rb) begin
      res.first_letter  = letter_at(ra, (ca + SIDE - 1) % SIDE);
      res.second_letter = letter_at(rb, (cb + SIDE - 1) % SIDE);
    end else if (ca == cb) begin
      res.first_letter  = letter_at((ra + SIDE - 1) % SIDE, ca);
      res.second_letter = letter_at((rb + SIDE - 1) % SIDE, cb);
    end else begin
      res.first_letter  = letter_at(ra, cb);
      res.second_letter = letter_at(rb, ca);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("mismatch %s: got %0d expected %0d at %0t ns", what, got, want, $time);
    error_count++;
  endtask

  always @(posedge clk) begin : result_check
    plain_pair_t want;
    if (rst) begin
      key_square = '0;
      plain_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= CFG_ROW4)
        key_square[cfg_index] = cfg_data;
      if (in_valid && in_ready)
        plain_expected.push_back(decrypt_digraph(cipher_first, cipher_second));
      if (out_valid && out_ready) begin
        if (plain_expected.size() == 0) begin
          report_mismatch("result with no item pending", 1, 0);
        end else begin
          want = plain_expected.pop_front();
          if (plain_first !== want.first_letter)
            report_mismatch("plain_first", plain_first, want.first_letter);
          if (plain_second !== want.second_letter)
            report_mismatch("plain_second", plain_second, want.second_letter);
          if (letter_missing !== want.missing)
            report_mismatch("letter_missing", letter_missing, want.missing);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_req) begin
      rx_hold_left = LONG_HOLD;
      rx_hold_req = 1'b0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
      rx_gap_left = pick_gap() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so the next item or flush_pipeline follows directly
  task automatic send_pair(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b);
    int gap;
    if (tx_idle_en && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    cipher_first  <= a;
    cipher_second <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic flush_pipeline();
    in_valid <= 1'b0;
    while (plain_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic load_square(input square_t sq);
    cfg_write(CFG_ROW0, sq[0]);
    cfg_write(CFG_ROW1, sq[1]);
    cfg_write(CFG_ROW2, sq[2]);
    cfg_write(CFG_ROW3, sq[3]);
    cfg_write(CFG_ROW4, sq[4]);
    cfg_valid <= 1'b0;
    stim_square = sq;
  endtask

  function automatic square_t alphabet_square();
    square_t sq;
    for (int k = 0; k < NCELL; k++)
      sq[k / SIDE][(k % SIDE)*CODE_W +: CODE_W] = CODE_W'(k);
    return sq;
  endfunction

  // 25 distinct letters out of 26, so one letter is always absent
  function automatic square_t shuffled_square();
    logic [CODE_W-1:0] letters [26];
    logic [CODE_W-1:0] tmp;
    int j;
    square_t sq;
    for (int i = 0; i < 26; i++) letters[i] = CODE_W'(i);
    for (int i = 25; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = letters[i];
      letters[i] = letters[j];
      letters[j] = tmp;
    end
    for (int k = 0; k < NCELL; k++)
      sq[k / SIDE][(k % SIDE)*CODE_W +: CODE_W] = letters[k];
    return sq;
  endfunction

  function automatic square_t repeated_letter_square();
    square_t sq;
    for (int k = 0; k < NCELL; k++)
      sq[k / SIDE][(k % SIDE)*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, 25));
    return sq;
  endfunction

  function automatic square_t raw_code_square();
    square_t sq;
    for (int r = 0; r < SIDE; r++) sq[r] = ROW_W'($urandom());
    return sq;
  endfunction

  function automatic logic [CODE_W-1:0] stim_cell(input int row, input int col);
    return stim_square[row][col*CODE_W +: CODE_W];
  endfunction

  task automatic send_random_pair();
    int kind, r1, r2, c1, c2;
    kind = $urandom_range(0, 99);
    r1 = $urandom_range(0, SIDE - 1);
    c1 = $urandom_range(0, SIDE - 1);
    r2 = $urandom_range(0, SIDE - 1);
    c2 = $urandom_range(0, SIDE - 1);
    if (kind < 28) begin
      send_pair(stim_cell(r1, c1), stim_cell(r1, c2));
    end else if (kind < 54) begin
      send_pair(stim_cell(r1, c1), stim_cell(r2, c1));
    end else if (kind < 84) begin
      if (r2 == r1) r2 = (r1 + 1 + $urandom_range(0, SIDE - 2)) % SIDE;
      if (c2 == c1) c2 = (c1 + 1 + $urandom_range(0, SIDE - 2)) % SIDE;
      send_pair(stim_cell(r1, c1), stim_cell(r2, c2));
    end else if (kind < 90) begin
      send_pair(stim_cell(r1, c1), stim_cell(r1, c1));
    end else begin
      send_pair(CODE_W'($urandom_range(0, 31)), CODE_W'($urandom_range(0, 31)));
    end
  endtask

  task automatic test_reset_square();
    // every cell holds letter a after reset
    send_pair(5'd0, 5'd0);
    send_pair(5'd0, 5'd1);
    send_pair(5'd31, 5'd31);
    flush_pipeline();
  endtask

  task automatic test_extreme_squares();
    load_square('1);
    send_pair(5'd31, 5'd31);
    send_pair(5'd0, 5'd31);
    flush_pipeline();
    load_square('0);
    send_pair(5'd0, 5'd31);
    flush_pipeline();
  endtask

  task automatic test_digraph_rules();
    load_square(alphabet_square());
    send_pair(5'd1, 5'd3);    // same row
    send_pair(5'd5, 5'd7);    // same row, wraps to column 4
    send_pair(5'd7, 5'd17);   // same column
    send_pair(5'd2, 5'd22);   // same column, wraps to row 4
    send_pair(5'd0, 5'd24);   // rectangle
    send_pair(5'd13, 5'd6);   // rectangle
    send_pair(5'd12, 5'd12);  // equal letters
    send_pair(5'd15, 5'd15);  // equal letters at column 0
    send_pair(5'd25, 5'd3);   // first letter absent
    send_pair(5'd3, 5'd25);   // second letter absent
    send_pair(5'd31, 5'd30);  // codes above z
    flush_pipeline();
  endtask

  task automatic test_repeated_letter();
    square_t sq;
    sq = alphabet_square();
    sq[4] = {SIDE{5'd6}};  // letter g also fills the last row
    load_square(sq);
    send_pair(5'd6, 5'd8);
    send_pair(5'd6, 5'd16);
    flush_pipeline();
  endtask

  task automatic test_unused_index();
    for (int i = SIDE; i < (1 << IDX_W); i++) cfg_write(IDX_W'(i), '1);
    cfg_valid <= 1'b0;
    send_pair(5'd3, 5'd14);
    flush_pipeline();
  endtask

  task automatic test_output_stall();
    load_square(shuffled_square());
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    repeat (24) send_random_pair();
    flush_pipeline();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        3:       load_square(repeated_letter_square());
        4:       load_square(raw_code_square());
        default: load_square(shuffled_square());
      endcase
      tx_idle_en = (phase != 1) && (phase != 3);
      rx_idle_en = (phase != 1) && (phase != 2);
      repeat (RAND_ITEMS) send_random_pair();
      flush_pipeline();
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    cipher_first  = '0;
    cipher_second = '0;
    out_ready     = 1'b0;
    error_count   = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_req   = 1'b0;
    rx_gap_left   = 0;
    rx_hold_left  = 0;
    stim_square   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_square();
    test_extreme_squares();
    test_digraph_rules();
    test_repeated_letter();
    test_unused_index();
    test_output_stall();
    test_random_traffic();

    if (plain_expected.size() != 0)
      report_mismatch("results never delivered", 0, plain_expected.size());
    if (error_count == 0) begin
      $display("playfair_digraph_decrypt_unit_tb: PASS");
    end else begin
      $display("playfair_digraph_decrypt_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
